FILE: hw/rtl/bmp_rle_stream_decoder_unit_defines.svh
// Assertion macros for the bitmap RLE stream decoder checker.
// Used by bmprle_checker; no other dependencies.
`ifndef BMP_RLE_STREAM_DECODER_UNIT_DEFINES_SVH
`define BMP_RLE_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define BMPRLE_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bmprle checker: property failed");

// next-cycle implication
`define BMPRLE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bmprle checker: property failed");

`endif

FILE: hw/rtl/bmprle_pkg.sv
// Shared types and codes for the bitmap RLE stream decoder.
// No dependencies; used by the palette, the top level and the checker.
package bmprle_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_B0,
      PH_B1,
      PH_ABS,
      PH_DX,
      PH_DY
   } phase_type;

   localparam logic [1:0] FUNC_BYTE    = 2'd0;
   localparam logic [1:0] FUNC_PALETTE = 2'd1;
   localparam logic [1:0] FUNC_START   = 2'd2;

   localparam logic [2:0] KIND_SPAN    = 3'd0;
   localparam logic [2:0] KIND_FILL    = 3'd1;
   localparam logic [2:0] KIND_DONE    = 3'd2;
   localparam logic [2:0] KIND_TRUNC   = 3'd3;
   localparam logic [2:0] KIND_CORRUPT = 3'd4;

   localparam logic [2:0] CSR_RLE4_MODE    = 3'd0;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_STREAM_BYTES = 3'd3;
   localparam logic [2:0] CSR_BACKGROUND   = 3'd4;

   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;
   localparam logic [7:0] ABS_MIN   = 8'd3;

   localparam logic [7:0]  NIB_MASK  = 8'd15;
   localparam logic [8:0]  EVEN_MASK = ~9'h1;
   localparam logic [16:0] MAX_DIM   = 17'd65535;
   localparam logic [31:0] PAL_RESET = 32'hFF00_0000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] start_x;
      logic [15:0] start_y;
      logic [7:0]  pixel_count;
      logic [15:0] end_x;
      logic [15:0] end_y;
      logic        last;
   } res_type;

   typedef struct packed {
      res_type     res;
      logic [31:0] color_even;
      logic [31:0] color_odd;
   } out_type;

endpackage

FILE: hw/rtl/bmp_rle_stream_decoder_unit.sv
// Top level of the bitmap RLE4/RLE8 stream decoder.
// Depends on bmprle_pkg and bmprle_palette.
//
// Usage:
//   req_*  : one word per handshake: a compressed byte, a palette write or an
//            image start, selected by req_func.
//   rsp_*  : result words (span, background fill, done, truncated, corrupt);
//            rsp_last marks the final result of one request word.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Path: a result word is registered in the read stage (palette read register),
//   then in the output register.
// Throughput: one request word per cycle while rsp_ready is high and each word
//   gives at most one result; a word with two results holds the result channel
//   until both are taken. The rate is set by the output register, which holds
//   the results of one request word and drains one result word per cycle.
// Reset: phase goes idle, cursor and counters clear, all palette entries read
//   as opaque black through per-entry valid bits; no clearing pass is needed.
// Stall: a result word holds until taken; one more request word is held in
//   the read stage, after that req_ready drops.
module bmp_rle_stream_decoder_unit #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [31:0] req_palette_color,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_start_x,
   output logic [15:0] rsp_start_y,
   output logic [7:0]  rsp_pixel_count,
   output logic [15:0] rsp_end_x,
   output logic [15:0] rsp_end_y,
   output logic [31:0] rsp_color_even,
   output logic [31:0] rsp_color_odd,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration
   logic        rle4_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic [31:0] stream_ff;

   // decoder state
   bmprle_pkg::phase_type phase_ff, phase_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  dx_ff, dx_in;
   logic [7:0]  rpl_ff, rpl_in;
   logic [7:0]  rbl_ff, rbl_in;

   // read stage and output register
   logic                s1_valid_ff;
   logic [1:0]          s1_num_ff, s1_num_in;
   logic                s1_rle4_ff;
   bmprle_pkg::res_type s1_res_ff [2];
   bmprle_pkg::res_type s1_res_in [2];
   logic [1:0]          out_num_ff;
   logic                out_pos_ff;
   bmprle_pkg::out_type out_ff [2];
   bmprle_pkg::out_type out_in [2];
   bmprle_pkg::out_type out_cur;

   logic        accept, start_go, byte_go;
   logic        s1_move, out_free, out_done, rsp_fire;
   logic [7:0]  b;
   logic [31:0] bl_dec;
   logic        bl_lt2;
   logic [15:0] room;
   logic [7:0]  take, span_req, vis;
   logic        span_en;
   logic [15:0] cx_span;
   logic [8:0]  abs_need, abs_rbl;
   logic        abs_trunc;
   logic [16:0] cy_inc;
   logic [15:0] ey_eol, ey_eob, ey_dlt;
   logic        eol_done;
   logic [16:0] tx, ty;
   logic        d_bad, d_done;
   logic        p_en, t_en;
   logic [2:0]  t_kind;
   bmprle_pkg::res_type p_res, t_res;
   logic [31:0] color_a, color_b;
   logic [7:0]  rd_index_a, rd_index_b;

   assign csr_ready = 1'b1;
   assign b         = req_data_byte;
   assign accept    = req_valid && req_ready;
   assign start_go  = accept && (req_func == bmprle_pkg::FUNC_START);
   assign byte_go   = accept && (req_func == bmprle_pkg::FUNC_BYTE)
                      && (phase_ff != bmprle_pkg::PH_IDLE);

   // background_color is applied downstream; writes to it are accepted and dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rle4_ff   <= 1'b0;
         width_ff  <= 16'd1;
         height_ff <= 16'd0;
         stream_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bmprle_pkg::CSR_RLE4_MODE:    rle4_ff   <= csr_data[0];
            bmprle_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[15:0];
            bmprle_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data[15:0];
            bmprle_pkg::CSR_STREAM_BYTES: stream_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // palette
   assign rd_index_a = rle4_ff ? (b >> 4) : b;
   assign rd_index_b = b & bmprle_pkg::NIB_MASK;

   bmprle_palette #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept && (req_func == bmprle_pkg::FUNC_PALETTE)),
      .wr_index   (req_palette_index),
      .wr_color   (req_palette_color),
      .rd_en      (accept),
      .rd_index_a (rd_index_a),
      .rd_index_b (rd_index_b),
      .color_a    (color_a),
      .color_b    (color_b)
   );

   // shared arithmetic
   always_comb begin
      bl_dec    = bytes_left_ff - 32'(bytes_left_ff != 32'd0);
      bl_lt2    = bl_dec < 32'd2;
      room      = (cursor_x_ff < width_ff) ? (width_ff - cursor_x_ff) : 16'd0;
      if (rle4_ff) begin
         take = (rpl_ff >= 8'd2) ? 8'd2 : rpl_ff;
      end else begin
         take = (rpl_ff != 8'd0) ? 8'd1 : 8'd0;
      end
      span_req  = (phase_ff == bmprle_pkg::PH_ABS) ? take : held_ff;
      vis       = ({8'd0, span_req} < room) ? span_req : room[7:0];
      span_en   = vis != 8'd0;
      cx_span   = cursor_x_ff + {8'd0, vis};
      if (rle4_ff) begin
         abs_need = (({1'b0, b} + 9'd3) >> 1) & bmprle_pkg::EVEN_MASK;
      end else begin
         abs_need = ({1'b0, b} + 9'd1) & bmprle_pkg::EVEN_MASK;
      end
      abs_rbl   = abs_need - 9'd1;
      abs_trunc = bl_dec < {23'd0, abs_need};
      cy_inc    = {1'b0, cursor_y_ff} + 17'd1;
      ey_eol    = (cy_inc > bmprle_pkg::MAX_DIM) ? 16'(bmprle_pkg::MAX_DIM) : cy_inc[15:0];
      eol_done  = ey_eol >= height_ff;
      ey_eob    = ({1'b0, height_ff} > bmprle_pkg::MAX_DIM) ?
                  16'(bmprle_pkg::MAX_DIM) : height_ff;
      tx        = {1'b0, cursor_x_ff} + {9'd0, dx_ff};
      ty        = {1'b0, cursor_y_ff} + {9'd0, b};
      d_bad     = (tx > {1'b0, width_ff}) || (ty > {1'b0, height_ff})
                  || ((ty == {1'b0, height_ff}) && (tx != 17'd0));
      d_done    = ty >= {1'b0, height_ff};
      ey_dlt    = (ty > bmprle_pkg::MAX_DIM) ? 16'(bmprle_pkg::MAX_DIM) : ty[15:0];
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (start_go) begin
         if ((stream_ff < 32'd2) || (height_ff == 16'd0)) begin
            phase_in = bmprle_pkg::PH_IDLE;
         end else begin
            phase_in = bmprle_pkg::PH_B0;
         end
      end else if (byte_go) begin
         unique case (phase_ff)
            bmprle_pkg::PH_B0: phase_in = bmprle_pkg::PH_B1;
            bmprle_pkg::PH_B1: begin
               priority if (held_ff != 8'd0) begin
                  phase_in = bl_lt2 ? bmprle_pkg::PH_IDLE : bmprle_pkg::PH_B0;
               end else if (b >= bmprle_pkg::ABS_MIN) begin
                  phase_in = abs_trunc ? bmprle_pkg::PH_IDLE : bmprle_pkg::PH_ABS;
               end else if (b == bmprle_pkg::ESC_EOL) begin
                  phase_in = (eol_done || bl_lt2) ? bmprle_pkg::PH_IDLE : bmprle_pkg::PH_B0;
               end else if (b == bmprle_pkg::ESC_EOB) begin
                  phase_in = bmprle_pkg::PH_IDLE;
               end else begin
                  phase_in = bl_lt2 ? bmprle_pkg::PH_IDLE : bmprle_pkg::PH_DX;
               end
            end
            bmprle_pkg::PH_ABS: begin
               if (rbl_ff == 8'd0) begin
                  phase_in = bl_lt2 ? bmprle_pkg::PH_IDLE : bmprle_pkg::PH_B0;
               end else begin
                  phase_in = bmprle_pkg::PH_ABS;
               end
            end
            bmprle_pkg::PH_DX: phase_in = bmprle_pkg::PH_DY;
            bmprle_pkg::PH_DY: begin
               phase_in = (d_bad || d_done || bl_lt2) ? bmprle_pkg::PH_IDLE : bmprle_pkg::PH_B0;
            end
            bmprle_pkg::PH_IDLE: phase_in = phase_ff;
         endcase
      end
   end

   // datapath and results
   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      bytes_left_in = bytes_left_ff;
      held_in       = held_ff;
      dx_in         = dx_ff;
      rpl_in        = rpl_ff;
      rbl_in        = rbl_ff;
      p_en          = 1'b0;
      t_en          = 1'b0;
      t_kind        = bmprle_pkg::KIND_DONE;
      p_res         = '0;
      p_res.kind    = bmprle_pkg::KIND_SPAN;
      p_res.start_x = cursor_x_ff;
      p_res.start_y = cursor_y_ff;
      p_res.pixel_count = vis;
      if (start_go) begin
         cursor_x_in   = 16'd0;
         cursor_y_in   = 16'd0;
         bytes_left_in = stream_ff;
         held_in       = 8'd0;
         dx_in         = 8'd0;
         rpl_in        = 8'd0;
         rbl_in        = 8'd0;
         if (stream_ff < 32'd2) begin
            t_en   = 1'b1;
            t_kind = bmprle_pkg::KIND_TRUNC;
         end else if (height_ff == 16'd0) begin
            t_en   = 1'b1;
         end
      end else if (byte_go) begin
         bytes_left_in = bl_dec;
         unique case (phase_ff)
            bmprle_pkg::PH_B0: held_in = b;
            bmprle_pkg::PH_B1: begin
               priority if (held_ff != 8'd0) begin
                  p_en        = span_en;
                  cursor_x_in = cx_span;
                  t_en        = bl_lt2;
                  t_kind      = bmprle_pkg::KIND_TRUNC;
               end else if (b >= bmprle_pkg::ABS_MIN) begin
                  t_en   = abs_trunc;
                  t_kind = bmprle_pkg::KIND_TRUNC;
                  rpl_in = b;
                  rbl_in = abs_rbl[7:0];
               end else if (b == bmprle_pkg::ESC_EOL) begin
                  p_en              = 1'b1;
                  p_res.kind        = bmprle_pkg::KIND_FILL;
                  p_res.pixel_count = 8'd0;
                  p_res.end_y       = ey_eol;
                  cursor_x_in       = 16'd0;
                  cursor_y_in       = ey_eol;
                  t_en              = eol_done || bl_lt2;
                  t_kind            = eol_done ? bmprle_pkg::KIND_DONE : bmprle_pkg::KIND_TRUNC;
               end else if (b == bmprle_pkg::ESC_EOB) begin
                  p_en              = 1'b1;
                  p_res.kind        = bmprle_pkg::KIND_FILL;
                  p_res.pixel_count = 8'd0;
                  p_res.end_y       = ey_eob;
                  cursor_x_in       = 16'd0;
                  cursor_y_in       = ey_eob;
                  t_en              = 1'b1;
               end else begin
                  t_en   = bl_lt2;
                  t_kind = bmprle_pkg::KIND_TRUNC;
               end
            end
            bmprle_pkg::PH_ABS: begin
               rpl_in      = rpl_ff - take;
               p_en        = span_en;
               cursor_x_in = cx_span;
               t_kind      = bmprle_pkg::KIND_TRUNC;
               if (rbl_ff == 8'd0) begin
                  t_en = bl_lt2;
               end else begin
                  rbl_in = rbl_ff - 8'd1;
               end
            end
            bmprle_pkg::PH_DX: dx_in = b;
            bmprle_pkg::PH_DY: begin
               if (d_bad) begin
                  t_en   = 1'b1;
                  t_kind = bmprle_pkg::KIND_CORRUPT;
               end else begin
                  p_en              = 1'b1;
                  p_res.kind        = bmprle_pkg::KIND_FILL;
                  p_res.pixel_count = 8'd0;
                  p_res.end_x       = tx[15:0];
                  p_res.end_y       = ey_dlt;
                  cursor_x_in       = tx[15:0];
                  cursor_y_in       = ey_dlt;
                  t_en              = d_done || bl_lt2;
                  t_kind            = d_done ? bmprle_pkg::KIND_DONE : bmprle_pkg::KIND_TRUNC;
               end
            end
            bmprle_pkg::PH_IDLE: begin
            end
         endcase
      end
      t_res         = '0;
      t_res.kind    = t_kind;
      t_res.last    = 1'b1;
      p_res.last    = !t_en;
      s1_res_in[0]  = p_en ? p_res : t_res;
      s1_res_in[1]  = t_res;
      s1_num_in     = {1'b0, p_en} + {1'b0, t_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bmprle_pkg::PH_IDLE;
         cursor_x_ff   <= 16'd0;
         cursor_y_ff   <= 16'd0;
         bytes_left_ff <= 32'd0;
         held_ff       <= 8'd0;
         dx_ff         <= 8'd0;
         rpl_ff        <= 8'd0;
         rbl_ff        <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         bytes_left_ff <= bytes_left_in;
         held_ff       <= held_in;
         dx_ff         <= dx_in;
         rpl_ff        <= rpl_in;
         rbl_ff        <= rbl_in;
      end
   end

   // read stage: palette colors are registered on accept and arrive in the next cycle
   assign rsp_fire = rsp_valid && rsp_ready;
   assign out_done = rsp_fire && (({1'b0, out_pos_ff} + 2'd1) == out_num_ff);
   assign out_free = (out_num_ff == 2'd0) || out_done;
   assign s1_move  = s1_valid_ff && ((s1_num_ff == 2'd0) || out_free);
   assign req_ready = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_num_ff   <= 2'd0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         s1_num_ff   <= s1_num_in;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff[0] <= s1_res_in[0];
         s1_res_ff[1] <= s1_res_in[1];
         s1_rle4_ff   <= rle4_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         out_in[i].res = s1_res_ff[i];
         if (s1_res_ff[i].kind == bmprle_pkg::KIND_SPAN) begin
            out_in[i].color_even = color_a;
            out_in[i].color_odd  = s1_rle4_ff ? color_b : color_a;
         end else begin
            out_in[i].color_even = 32'd0;
            out_in[i].color_odd  = 32'd0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_num_ff <= 2'd0;
         out_pos_ff <= 1'b0;
      end else if (s1_move && (s1_num_ff != 2'd0)) begin
         out_num_ff <= s1_num_ff;
         out_pos_ff <= 1'b0;
      end else if (out_done) begin
         out_num_ff <= 2'd0;
         out_pos_ff <= 1'b0;
      end else if (rsp_fire) begin
         out_pos_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && (s1_num_ff != 2'd0)) begin
         out_ff[0] <= out_in[0];
         out_ff[1] <= out_in[1];
      end
   end

   assign out_cur         = out_ff[out_pos_ff];
   assign rsp_valid       = out_num_ff != 2'd0;
   assign rsp_kind        = out_cur.res.kind;
   assign rsp_start_x     = out_cur.res.start_x;
   assign rsp_start_y     = out_cur.res.start_y;
   assign rsp_pixel_count = out_cur.res.pixel_count;
   assign rsp_end_x       = out_cur.res.end_x;
   assign rsp_end_y       = out_cur.res.end_y;
   assign rsp_color_even  = out_cur.color_even;
   assign rsp_color_odd   = out_cur.color_odd;
   assign rsp_last        = out_cur.res.last;

endmodule

FILE: hw/rtl/bmprle_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module bmprle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hw/rtl/bmprle_palette.sv
// Color palette: RAM with per-entry valid bits so unwritten entries read opaque black.
// Depends on bmprle_pkg and bmprle_ram.
module bmprle_palette #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [7:0]  wr_index,
   input  logic [31:0] wr_color,
   input  logic        rd_en,
   input  logic [7:0]  rd_index_a,
   input  logic [7:0]  rd_index_b,
   output logic [31:0] color_a,
   output logic [31:0] color_b
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [PALETTE_DEPTH-1:0] valid_ff;
   logic                     hit_a_ff;
   logic                     hit_b_ff;
   logic                     wr_ok;
   logic                     rd_ok_a;
   logic                     rd_ok_b;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;
   logic [31:0]              ram_a;
   logic [31:0]              ram_b;

   assign wr_ok     = wr_en && ({1'b0, wr_index} < 9'(PALETTE_DEPTH));
   assign rd_ok_a   = {1'b0, rd_index_a} < 9'(PALETTE_DEPTH);
   assign rd_ok_b   = {1'b0, rd_index_b} < 9'(PALETTE_DEPTH);
   assign wr_addr   = wr_index[AW-1:0];
   assign rd_addr_a = rd_index_a[AW-1:0];
   assign rd_addr_b = rd_index_b[AW-1:0];

   bmprle_ram #(
      .WIDTH(32),
      .DEPTH(PALETTE_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_ok),
      .wr_addr   (wr_addr),
      .wr_data   (wr_color),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_a_ff <= rd_ok_a && valid_ff[rd_addr_a];
            hit_b_ff <= rd_ok_b && valid_ff[rd_addr_b];
         end
      end
   end

   assign color_a = hit_a_ff ? ram_a : bmprle_pkg::PAL_RESET;
   assign color_b = hit_b_ff ? ram_b : bmprle_pkg::PAL_RESET;

endmodule

FILE: hw/rtl/bmprle_checker.sv
// Port-level checker for the bitmap RLE stream decoder, with its bind.
// Depends on bmprle_pkg and bmp_rle_stream_decoder_unit_defines.svh.
`include "bmp_rle_stream_decoder_unit_defines.svh"

module bmprle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [15:0] rsp_start_x,
   input logic [7:0]  rsp_pixel_count,
   input logic [31:0] rsp_color_even,
   input logic [31:0] rsp_color_odd,
   input logic        rsp_last
);

   `BMPRLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready && !reset, reset || (rsp_valid && $stable(rsp_kind) && $stable(rsp_start_x) && $stable(rsp_last)))
   `BMPRLE_ASSERT_IMP(a_span_nonempty, clock, reset, rsp_valid && (rsp_kind == bmprle_pkg::KIND_SPAN), rsp_pixel_count != 8'd0)
   `BMPRLE_ASSERT_IMP(a_end_is_last, clock, reset, rsp_valid && ((rsp_kind == bmprle_pkg::KIND_DONE) || (rsp_kind == bmprle_pkg::KIND_TRUNC) || (rsp_kind == bmprle_pkg::KIND_CORRUPT)), rsp_last)
   `BMPRLE_ASSERT_IMP(a_nospan_plain, clock, reset, rsp_valid && (rsp_kind != bmprle_pkg::KIND_SPAN), (rsp_color_even == 32'd0) && (rsp_color_odd == 32'd0) && (rsp_pixel_count == 8'd0))
   `BMPRLE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind bmp_rle_stream_decoder_unit bmprle_checker u_checker (.*);

FILE: tb/sv/bmp_rle_stream_decoder_unit_tb.sv
// Self-checking bench for bmp_rle_stream_decoder_unit: feeds RLE8/RLE4 byte streams,
// palette writes and image starts, and checks every span, fill and end word in order.
// Depends on bmprle_pkg and the decoder RTL only.
module bmp_rle_stream_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_WORDS = 50;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  data;
      logic [7:0]  pidx;
      logic [31:0] pcolor;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] start_x;
      logic [15:0] start_y;
      logic [7:0]  pixel_count;
      logic [15:0] end_x;
      logic [15:0] end_y;
      logic [31:0] color_even;
      logic [31:0] color_odd;
      logic        last;
   } rle_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_palette_index = '0;
   logic [31:0] req_palette_color = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_start_x;
   logic [15:0] rsp_start_y;
   logic [7:0]  rsp_pixel_count;
   logic [15:0] rsp_end_x;
   logic [15:0] rsp_end_y;
   logic [31:0] rsp_color_even;
   logic [31:0] rsp_color_odd;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   bmp_rle_stream_decoder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_data_byte(req_data_byte),
      .req_palette_index(req_palette_index),
      .req_palette_color(req_palette_color),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_start_x(rsp_start_x),
      .rsp_start_y(rsp_start_y),
      .rsp_pixel_count(rsp_pixel_count),
      .rsp_end_x(rsp_end_x),
      .rsp_end_y(rsp_end_y),
      .rsp_color_even(rsp_color_even),
      .rsp_color_odd(rsp_color_odd),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   req_word_type   pending_words[$];
   rle_result_type decoder_out_q[$];
   req_word_type   word_on_bus;
   logic        word_taken = 1'b0;
   int unsigned words_queued = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;

   logic        cfg_rle4 = 1'b0;
   logic [15:0] cfg_width = 16'd1;
   logic [15:0] cfg_height = 16'd0;
   logic [31:0] cfg_stream = 32'd0;
   logic [31:0] cfg_background = 32'd0;

   logic [31:0] palette_mem [256];
   logic [15:0] cur_x = '0;
   logic [15:0] cur_y = '0;
   logic [31:0] budget = '0;
   bmprle_pkg::phase_type dec_phase = bmprle_pkg::PH_IDLE;
   logic [7:0]  held_count = '0;
   logic [7:0]  delta_cols = '0;
   logic [7:0]  abs_pixels = '0;
   logic [7:0]  abs_bytes = '0;
   int unsigned step_results;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic add_result(logic [2:0] k, int unsigned sx, int unsigned sy,
                             int unsigned cnt, int unsigned ex, int unsigned ey,
                             logic [31:0] ce, logic [31:0] co);
      rle_result_type r;
      r.kind        = k;
      r.start_x     = sx[15:0];
      r.start_y     = sy[15:0];
      r.pixel_count = cnt[7:0];
      r.end_x       = ex[15:0];
      r.end_y       = ey[15:0];
      r.color_even  = ce;
      r.color_odd   = co;
      r.last        = 1'b0;
      decoder_out_q.push_back(r);
      step_results++;
   endtask

   task automatic finish_image(logic [2:0] k);
      add_result(k, 0, 0, 0, 0, 0, 32'd0, 32'd0);
      dec_phase = bmprle_pkg::PH_IDLE;
   endtask

   task automatic fill_to(int unsigned tx, int unsigned ty);
      int unsigned ey;
      ey = (ty > 32'(bmprle_pkg::MAX_DIM)) ? 32'(bmprle_pkg::MAX_DIM) : ty;
      add_result(bmprle_pkg::KIND_FILL, cur_x, cur_y, 0, tx, ey, 32'd0, 32'd0);
      cur_x = tx[15:0];
      cur_y = ey[15:0];
   endtask

   task automatic next_command();
      if (budget < 2) begin
         finish_image(bmprle_pkg::KIND_TRUNC);
      end else begin
         dec_phase = bmprle_pkg::PH_B0;
      end
   endtask

   task automatic paint_span(int unsigned cnt, logic [31:0] ce, logic [31:0] co);
      int unsigned room;
      int unsigned vis;
      room = (cur_x < cfg_width) ? 32'(cfg_width) - 32'(cur_x) : 0;
      vis  = (cnt < room) ? cnt : room;
      if (vis != 0) begin
         add_result(bmprle_pkg::KIND_SPAN, cur_x, cur_y, vis, 0, 0, ce, co);
         cur_x = 16'(32'(cur_x) + vis);
      end
   endtask

   task automatic pick_colors(logic [7:0] b, output logic [31:0] ce, output logic [31:0] co);
      ce = cfg_rle4 ? palette_mem[b >> 4] : palette_mem[b];
      co = cfg_rle4 ? palette_mem[b & bmprle_pkg::NIB_MASK] : ce;
   endtask

   task automatic close_pair(logic [7:0] b);
      int unsigned n;
      int unsigned need;
      logic [31:0] ce;
      logic [31:0] co;
      n = 32'(b);
      if (held_count != 0) begin
         pick_colors(b, ce, co);
         paint_span(32'(held_count), ce, co);
         next_command();
      end else if (b >= bmprle_pkg::ABS_MIN) begin
         need = cfg_rle4 ? (((n + 3) >> 1) & 32'(bmprle_pkg::EVEN_MASK))
                         : ((n + 1) & 32'(bmprle_pkg::EVEN_MASK));
         if (budget < need) begin
            finish_image(bmprle_pkg::KIND_TRUNC);
         end else begin
            abs_pixels = b;
            abs_bytes  = 8'(need - 1);
            dec_phase  = bmprle_pkg::PH_ABS;
         end
      end else if (b == bmprle_pkg::ESC_EOL) begin
         fill_to(0, 32'(cur_y) + 1);
         if (32'(cur_y) + 1 > 32'(cfg_height) || cur_y >= cfg_height) begin
            finish_image(bmprle_pkg::KIND_DONE);
         end else begin
            next_command();
         end
      end else if (b == bmprle_pkg::ESC_EOB) begin
         fill_to(0, 32'(cfg_height));
         finish_image(bmprle_pkg::KIND_DONE);
      end else if (budget < 2) begin
         finish_image(bmprle_pkg::KIND_TRUNC);
      end else begin
         dec_phase = bmprle_pkg::PH_DX;
      end
   endtask

   task automatic absolute_byte(logic [7:0] b);
      int unsigned per;
      int unsigned take;
      logic [31:0] ce;
      logic [31:0] co;
      per  = cfg_rle4 ? 2 : 1;
      take = (per < 32'(abs_pixels)) ? per : 32'(abs_pixels);
      abs_pixels = abs_pixels - 8'(take);
      if (take != 0) begin
         pick_colors(b, ce, co);
         paint_span(take, ce, co);
      end
      if (abs_bytes == 0) begin
         next_command();
      end else begin
         abs_bytes = abs_bytes - 8'd1;
      end
   endtask

   task automatic finish_delta(logic [7:0] dy);
      int unsigned tx;
      int unsigned ty;
      tx = 32'(cur_x) + 32'(delta_cols);
      ty = 32'(cur_y) + 32'(dy);
      if (tx > 32'(cfg_width) || ty > 32'(cfg_height) ||
          (ty == 32'(cfg_height) && tx != 0)) begin
         finish_image(bmprle_pkg::KIND_CORRUPT);
      end else begin
         fill_to(tx, ty);
         if (ty >= 32'(cfg_height)) begin
            finish_image(bmprle_pkg::KIND_DONE);
         end else begin
            next_command();
         end
      end
   endtask

   task automatic decode_request(req_word_type w);
      step_results = 0;
      case (w.func)
         bmprle_pkg::FUNC_PALETTE: palette_mem[w.pidx] = w.pcolor;
         bmprle_pkg::FUNC_START: begin
            cur_x      = '0;
            cur_y      = '0;
            budget     = cfg_stream;
            held_count = '0;
            delta_cols = '0;
            abs_pixels = '0;
            abs_bytes  = '0;
            if (budget < 2) begin
               finish_image(bmprle_pkg::KIND_TRUNC);
            end else if (cfg_height == 0) begin
               finish_image(bmprle_pkg::KIND_DONE);
            end else begin
               dec_phase = bmprle_pkg::PH_B0;
            end
         end
         bmprle_pkg::FUNC_BYTE: begin
            if (dec_phase != bmprle_pkg::PH_IDLE) begin
               if (budget != 0) budget = budget - 1;
               case (dec_phase)
                  bmprle_pkg::PH_B0: begin
                     held_count = w.data;
                     dec_phase  = bmprle_pkg::PH_B1;
                  end
                  bmprle_pkg::PH_B1: close_pair(w.data);
                  bmprle_pkg::PH_ABS: absolute_byte(w.data);
                  bmprle_pkg::PH_DX: begin
                     delta_cols = w.data;
                     dec_phase  = bmprle_pkg::PH_DY;
                  end
                  default: finish_delta(w.data);
               endcase
            end
         end
         default: ;
      endcase
      if (step_results > 0) decoder_out_q[decoder_out_q.size() - 1].last = 1'b1;
   endtask

   task automatic queue_word(logic [1:0] f, logic [7:0] d, logic [7:0] idx, logic [31:0] col);
      req_word_type w;
      w.func   = f;
      w.data   = d;
      w.pidx   = idx;
      w.pcolor = col;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic queue_byte(logic [7:0] d);
      queue_word(bmprle_pkg::FUNC_BYTE, d, 8'($urandom), $urandom);
   endtask

   task automatic queue_image(logic rle4_on);
      int unsigned cmds;
      int unsigned pick;
      int unsigned n;
      int unsigned padded;
      queue_word(bmprle_pkg::FUNC_START, 8'($urandom), 8'($urandom), $urandom);
      cmds = $urandom_range(14, 2);
      repeat (cmds) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
            queue_byte(8'(n));
            queue_byte(8'($urandom));
         end else if (pick < 48) begin
            queue_byte(8'd0);
            queue_byte(bmprle_pkg::ESC_EOL);
         end else if (pick < 62) begin
            queue_byte(8'd0);
            queue_byte(bmprle_pkg::ESC_DELTA);
            if ($urandom_range(7) == 0) begin
               queue_byte(8'($urandom));
               queue_byte(8'($urandom));
            end else begin
               queue_byte(8'($urandom_range(5)));
               queue_byte(8'($urandom_range(2)));
            end
         end else if (pick < 82) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(255, 3) : $urandom_range(14, 3);
            padded = rle4_on ? (((n + 3) >> 1) & 32'(bmprle_pkg::EVEN_MASK))
                             : ((n + 1) & 32'(bmprle_pkg::EVEN_MASK));
            if ($urandom_range(11) == 0) padded = $urandom_range(padded - 1);
            queue_byte(8'd0);
            queue_byte(8'(n));
            repeat (padded) queue_byte(8'($urandom));
         end else if (pick < 90) begin
            queue_word(bmprle_pkg::FUNC_PALETTE, 8'($urandom),
                       $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom), $urandom);
         end else if (pick < 96) begin
            queue_word(2'($urandom_range(3)), 8'($urandom), 8'($urandom), $urandom);
         end else begin
            queue_byte(8'd0);
            queue_byte(bmprle_pkg::ESC_EOB);
         end
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bmprle_pkg::CSR_RLE4_MODE:    cfg_rle4 = val[0];
         bmprle_pkg::CSR_IMAGE_WIDTH:  cfg_width = val[15:0];
         bmprle_pkg::CSR_IMAGE_HEIGHT: cfg_height = val[15:0];
         bmprle_pkg::CSR_STREAM_BYTES: cfg_stream = val;
         bmprle_pkg::CSR_BACKGROUND:   cfg_background = val;
         default: ;
      endcase
   endtask

   task automatic set_config(logic rle4, logic [15:0] w, logic [15:0] h,
                             logic [31:0] sb, logic [31:0] bg);
      write_reg(bmprle_pkg::CSR_RLE4_MODE, 32'(rle4));
      write_reg(bmprle_pkg::CSR_IMAGE_WIDTH, 32'(w));
      write_reg(bmprle_pkg::CSR_IMAGE_HEIGHT, 32'(h));
      write_reg(bmprle_pkg::CSR_STREAM_BYTES, sb);
      write_reg(bmprle_pkg::CSR_BACKGROUND, bg);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_words.size() != 0 || req_valid || decoder_out_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      word_taken = !reset && req_valid && req_ready;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (word_taken) decode_request(word_on_bus);
         if (!req_valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               word_on_bus = pending_words.pop_front();
               req_valid         <= 1'b1;
               req_func          <= word_on_bus.func;
               req_data_byte     <= word_on_bus.data;
               req_palette_index <= word_on_bus.pidx;
               req_palette_color <= word_on_bus.pcolor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rle_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoder_out_q.size() == 0) begin
            $display("%0t: kind expected none actual %0d", $time, rsp_kind);
            mismatch_count++;
         end else begin
            want = decoder_out_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_kind));
            compare_field("start_x", 32'(want.start_x), 32'(rsp_start_x));
            compare_field("start_y", 32'(want.start_y), 32'(rsp_start_y));
            compare_field("pixel_count", 32'(want.pixel_count), 32'(rsp_pixel_count));
            compare_field("end_x", 32'(want.end_x), 32'(rsp_end_x));
            compare_field("end_y", 32'(want.end_y), 32'(rsp_end_y));
            compare_field("color_even", want.color_even, rsp_color_even);
            compare_field("color_odd", want.color_odd, rsp_color_odd);
            compare_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned ph;
      int unsigned target;
      for (int i = 0; i < 256; i++) palette_mem[i] = bmprle_pkg::PAL_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 68;

      set_config(1'b0, 16'd4, 16'd0, 32'd1, 32'hFFFF_FFFF);
      queue_byte(8'h55);
      queue_word(FUNC_UNUSED, 8'hAA, 8'h5A, 32'h0F0F_0F0F);
      queue_word(bmprle_pkg::FUNC_PALETTE, 8'h00, 8'd255, 32'hFFFF_FFFF);
      queue_word(bmprle_pkg::FUNC_START, 8'hFF, 8'hFF, 32'hF0F0_F0F0);
      wait_idle();

      set_config(1'b0, 16'd4, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(bmprle_pkg::FUNC_START, 8'h00, 8'h00, 32'h0);
      wait_idle();

      set_config(1'b0, 16'd4, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_word(bmprle_pkg::FUNC_START, 8'h00, 8'h00, 32'h0);
      queue_byte(8'd5);
      queue_byte(8'hFF);
      queue_byte(8'd0);
      queue_byte(bmprle_pkg::ABS_MIN);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h80);
      queue_byte(8'h01);
      queue_byte(8'd0);
      queue_byte(bmprle_pkg::ESC_EOL);
      queue_byte(8'd0);
      queue_byte(bmprle_pkg::ESC_DELTA);
      queue_byte(8'd9);
      queue_byte(8'd0);
      wait_idle();

      set_config(1'b1, 16'hFFFF, 16'hFFFF, 32'd8, 32'd0);
      queue_word(bmprle_pkg::FUNC_START, 8'h00, 8'h00, 32'h0);
      queue_byte(8'd0);
      queue_byte(8'd4);
      queue_byte(8'h0F);
      queue_byte(8'hF0);
      queue_byte(8'd0);
      queue_byte(bmprle_pkg::ESC_EOB);
      wait_idle();

      for (ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 68;
         end else if (ph < 6) begin
            send_idle_pct = 68;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: set_config(1'b0, 16'd8, 16'd4, 32'hFFFF_FFFF, 32'd0);
            1: set_config(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: set_config(1'b0, 16'd1, 16'd3, 32'd40, $urandom);
            3: set_config(1'b1, 16'($urandom_range(32, 2)), 16'($urandom_range(8, 1)),
                          $urandom_range(200, 20), $urandom);
            4: set_config(1'b0, 16'hFFFF, 16'd1, 32'hFFFF_FFFF, 32'd0);
            5: set_config(1'b1, 16'd5, 16'hFFFF, 32'd30, $urandom);
            default: set_config(1'($urandom_range(1)), 16'($urandom_range(40, 1)),
                                16'($urandom_range(10, 1)), $urandom_range(400, 8), $urandom);
         endcase
         target = words_queued + PHASE_WORDS;
         while (words_queued < target) queue_image(cfg_rle4);
         wait_idle();
      end

      if (mismatch_count == 0 && decoder_out_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bmprle_pkg.sv
hw/rtl/bmprle_ram.sv
hw/rtl/bmprle_palette.sv
hw/rtl/bmp_rle_stream_decoder_unit.sv
hw/rtl/bmprle_checker.sv
tb/sv/bmp_rle_stream_decoder_unit_tb.sv
